/* design/fvlw_pkg.sv */
// shared types, codes and record helpers for the flash variable log writer
`timescale 1ns / 1ps
package fvlw_pkg;

  localparam logic [1:0] FUNC_SET      = 2'd0;
  localparam logic [1:0] FUNC_STEP     = 2'd1;
  localparam logic [1:0] FUNC_READBACK = 2'd2;
  localparam logic [1:0] FUNC_INIT     = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_ERASE = 2'd3;

  localparam logic [2:0] REG_BASE0   = 3'd0;
  localparam logic [2:0] REG_BASE1   = 3'd1;
  localparam logic [2:0] REG_BASE2   = 3'd2;
  localparam logic [2:0] REG_SECTOR0 = 3'd3;
  localparam logic [2:0] REG_SECTOR1 = 3'd4;
  localparam logic [2:0] REG_SECTOR2 = 3'd5;
  localparam logic [2:0] REG_PAGE_BYTES = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_WRITE_CHECK  = 3'd1,
    MODE_NEWPAGE      = 3'd2,
    MODE_WAIT_WRITE   = 3'd3,
    MODE_WAIT_NEWPAGE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CHK0 = 3'd1,
    PH_CHK1 = 3'd2,
    PH_COPY = 3'd3,
    PH_RB   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] base0;
    logic [31:0] base1;
    logic [31:0] base2;
    logic [7:0]  sector0;
    logic [7:0]  sector1;
    logic [7:0]  sector2;
    logic [20:0] page_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] flash_address;
    logic [63:0] record_word;
    logic [7:0]  erase_sector;
    logic        verify_ok;
    logic        last;
  } result_t;

  function automatic logic [15:0] rec_crc(input logic [47:0] d);
    logic [15:0] c;
    c = CRC_INIT;
    for (int b = 0; b < 6; b++) begin
      c = c ^ {d[8*b +: 8], 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] build_record(input logic [31:0] value,
                                               input logic [7:0] idx);
    logic [47:0] body;
    body = {~idx, idx, value};
    return {rec_crc(body), body};
  endfunction

  function automatic logic [31:0] page_base(input cfg_t cfg, input logic [1:0] p);
    logic [31:0] b;
    case (p)
      2'd0:    b = cfg.base0;
      2'd1:    b = cfg.base1;
      default: b = cfg.base2;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] page_sector(input cfg_t cfg, input logic [1:0] p);
    logic [7:0] s;
    case (p)
      2'd0:    s = cfg.sector0;
      2'd1:    s = cfg.sector1;
      default: s = cfg.sector2;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] next_page(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

endpackage

/* design/fvlw_table.sv */
// variable table: synchronous memory with per-entry valid bits, unwritten reads as zero
`timescale 1ns / 1ps
module fvlw_table #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [31:0]    rd_raw_r;
  logic           rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : 32'd0;

endmodule

/* design/fvlw_outq.sv */
// four-entry result queue taking up to three results per cycle
`timescale 1ns / 1ps
module fvlw_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  fvlw_pkg::result_t   push_res [3],
  input  logic                pop,
  output fvlw_pkg::result_t   head,
  output logic                not_empty,
  output logic                room
);
  import fvlw_pkg::*;

  result_t    q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 3'd0);
  assign room      = (cnt_r <= 3'd1);
  assign head      = q_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_n) begin
        q_r[wp_r + 2'(k)] <= push_res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> ({1'b0, cnt_r} + {2'b00, push_n}) <= (4'd4 + {3'b000, pop}))
    else $error("result queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0 && !pop) |=> cnt_r == $past(cnt_r) + {1'b0, $past(push_n)})
    else $error("result queue count lost a push");
`endif

endmodule

/* design/fvlw_ctrl.sv */
// step sequencer: reads tables, builds records, checks readbacks, emits results
`timescale 1ns / 1ps
module fvlw_ctrl #(
  parameter int NUM_VARS = 32,
  parameter int AW       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fvlw_pkg::cfg_t     cfg,
  input  logic               room,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [4:0]         in_var_index,
  input  logic [31:0]        in_var_value,
  input  logic               in_write_ready,
  input  logic               in_read_ready,
  input  logic               in_erase_ready,
  input  logic [63:0]        in_readback_record,
  input  logic               in_fresh_start,
  output logic [1:0]         push_n,
  output fvlw_pkg::result_t  push_res [3]
);
  import fvlw_pkg::*;

  localparam logic [7:0] NV = 8'(NUM_VARS);

  phase_t      phase_r, phase_nxt;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  scan_r, scan_nxt;
  logic [20:0] offset_r, offset_nxt;
  logic [1:0]  page_r, page_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        wr_r, wr_nxt, rd_r, rd_nxt;
  logic [63:0] rb_r, rb_nxt;

  logic          accept, equal;
  logic [AW-1:0] rd_addr;
  logic          live_we, stored_we, clr;
  logic [AW-1:0] live_wa, stored_wa;
  logic [31:0]   live_wd, stored_wd, live_q, stored_q;
  logic [7:0]    idx_inc, scan0, vi8;
  logic          ex_en, ex_check;
  logic [31:0]   ex_addr;
  mode_t         ex_wait;
  logic [63:0]   ex_rec;
  logic          over, rb_ok;
  logic [7:0]    rb_idx;

  fvlw_table #(.DEPTH(NUM_VARS), .AW(AW)) u_live (
    .clk, .rst_n, .clear(clr), .wr_en(live_we), .wr_addr(live_wa),
    .wr_data(live_wd), .rd_addr(rd_addr), .rd_data(live_q)
  );

  fvlw_table #(.DEPTH(NUM_VARS), .AW(AW)) u_stored (
    .clk, .rst_n, .clear(clr), .wr_en(stored_we), .wr_addr(stored_wa),
    .wr_data(stored_wd), .rd_addr(rd_addr), .rd_data(stored_q)
  );

  assign in_ready = (phase_r == PH_IDLE) && room;
  assign accept   = in_valid && in_ready;
  assign equal    = (live_q == stored_q);
  assign idx_inc  = (idx_r + 8'd1 == NV) ? 8'd0 : idx_r + 8'd1;
  assign scan0    = (scan_r >= NV) ? 8'd0 : scan_r;
  assign vi8      = {3'b000, in_var_index};
  assign over     = ({1'b0, offset_r} + 22'd8) > {1'b0, cfg.page_bytes};
  assign ex_rec   = build_record(live_q, idx_r);
  assign rb_idx   = rb_r[39:32];
  assign rb_ok    = (rec_crc(rb_r[47:0]) == rb_r[63:48])
                    && (rb_idx == (rb_r[47:40] ^ BYTE_ONES)) && (rb_idx < NV);

  // next phase
  always_comb begin
    phase_nxt = PH_IDLE;
    case (phase_r)
      PH_IDLE: begin
        if (accept && in_func == FUNC_STEP && mode_r == MODE_WRITE_CHECK) begin
          phase_nxt = PH_CHK0;
        end else if (accept && in_func == FUNC_STEP && mode_r == MODE_NEWPAGE
                     && scan_r < NV) begin
          phase_nxt = PH_COPY;
        end else if (accept && in_func == FUNC_READBACK) begin
          phase_nxt = PH_RB;
        end
      end
      PH_CHK0: phase_nxt = equal ? PH_CHK1 : PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    mode_nxt   = mode_r;
    scan_nxt   = scan_r;
    offset_nxt = offset_r;
    page_nxt   = page_r;
    idx_nxt    = idx_r;
    wr_nxt     = wr_r;
    rd_nxt     = rd_r;
    rb_nxt     = rb_r;
    rd_addr    = idx_r[AW-1:0];
    live_we    = 1'b0;
    live_wa    = vi8[AW-1:0];
    live_wd    = in_var_value;
    stored_we  = 1'b0;
    stored_wa  = idx_r[AW-1:0];
    stored_wd  = live_q;
    clr        = 1'b0;
    ex_en      = 1'b0;
    ex_check   = 1'b0;
    ex_addr    = page_base(cfg, page_r) + {11'd0, offset_r};
    ex_wait    = MODE_WAIT_WRITE;
    push_n     = 2'd0;
    for (int k = 0; k < 3; k++) begin
      push_res[k] = '0;
    end

    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          wr_nxt = in_write_ready;
          rd_nxt = in_read_ready;
          rb_nxt = in_readback_record;
          case (in_func)
            FUNC_SET: begin
              live_we = (vi8 < NV);
            end
            FUNC_STEP: begin
              if (mode_r == MODE_WRITE_CHECK) begin
                scan_nxt = scan0;
                idx_nxt  = scan0;
                rd_addr  = scan0[AW-1:0];
              end else if (mode_r == MODE_NEWPAGE) begin
                if (scan_r < NV) begin
                  idx_nxt = scan_r;
                  rd_addr = scan_r[AW-1:0];
                end else if (in_erase_ready) begin
                  push_n = 2'd1;
                  push_res[0].command      = CMD_ERASE;
                  push_res[0].erase_sector = page_sector(cfg, page_r);
                  page_nxt = next_page(page_r);
                  scan_nxt = 8'd0;
                  mode_nxt = MODE_WRITE_CHECK;
                end
              end
            end
            FUNC_READBACK: begin
              rd_addr = in_readback_record[32 +: AW];
            end
            default: begin
              clr        = 1'b1;
              scan_nxt   = 8'd0;
              offset_nxt = 21'd0;
              page_nxt   = 2'd0;
              if (in_fresh_start) begin
                mode_nxt = MODE_WRITE_CHECK;
                push_n   = 2'd3;
                for (int k = 0; k < 3; k++) begin
                  push_res[k].command      = CMD_ERASE;
                  push_res[k].erase_sector = page_sector(cfg, 2'(k));
                end
              end
            end
          endcase
        end
      end
      PH_CHK0: begin
        if (equal) begin
          idx_nxt  = idx_inc;
          scan_nxt = idx_inc;
          rd_addr  = idx_inc[AW-1:0];
        end else begin
          ex_en    = 1'b1;
          ex_check = 1'b1;
        end
      end
      PH_CHK1: begin
        ex_en    = !equal;
        ex_check = 1'b1;
      end
      PH_COPY: begin
        stored_we = 1'b1;
        ex_en     = 1'b1;
        ex_addr   = page_base(cfg, next_page(page_r)) + {11'd0, offset_r};
        ex_wait   = MODE_WAIT_NEWPAGE;
      end
      PH_RB: begin
        push_n = 2'd1;
        push_res[0].verify_ok = rb_ok;
        if (mode_r == MODE_WAIT_WRITE) begin
          stored_we = rb_ok;
          stored_wa = rb_idx[AW-1:0];
          stored_wd = rb_r[31:0];
          mode_nxt  = MODE_WRITE_CHECK;
        end else if (mode_r == MODE_WAIT_NEWPAGE) begin
          push_res[0].verify_ok = rb_ok && (stored_q == rb_r[31:0]);
          if (rb_ok && (stored_q == rb_r[31:0])) begin
            scan_nxt = scan_r + 8'd1;
          end
          mode_nxt = MODE_NEWPAGE;
        end
      end
      default: begin
      end
    endcase

    if (ex_en) begin
      if (ex_check && over) begin
        mode_nxt   = MODE_NEWPAGE;
        scan_nxt   = 8'd0;
        offset_nxt = 21'd0;
      end else if (wr_r) begin
        push_n = 2'd1;
        push_res[0].command       = CMD_WRITE;
        push_res[0].flash_address = ex_addr;
        push_res[0].record_word   = ex_rec;
        offset_nxt = offset_r + 21'd8;
        if (rd_r) begin
          push_n = 2'd2;
          push_res[1].command       = CMD_READ;
          push_res[1].flash_address = ex_addr;
          mode_nxt = ex_wait;
        end
      end
    end

    case (push_n)
      2'd1:    push_res[0].last = 1'b1;
      2'd2:    push_res[1].last = 1'b1;
      2'd3:    push_res[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      mode_r   <= MODE_IDLE;
      scan_r   <= '0;
      offset_r <= '0;
      page_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      scan_r   <= scan_nxt;
      offset_r <= offset_nxt;
      page_r   <= page_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    wr_r  <= wr_nxt;
    rd_r  <= rd_nxt;
    rb_r  <= rb_nxt;
  end

`ifndef SYNTHESIS
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n) page_r != 2'd3)
    else $error("active page out of range");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> phase_r == PH_IDLE && room)
    else $error("item taken while sequencer busy");
  a_chk1_order: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHK1 |-> $past(phase_r) == PH_CHK0)
    else $error("second compare without first");
`endif

endmodule

/* design/flash_variable_log_writer_top.sv */
// top level: configuration registers, step sequencer and result queue
`timescale 1ns / 1ps
// Flash variable log writer.
// Input channel (in_valid / in_stall): one item per transfer, func selects set
// variable, process step, flash readback or initialize. Result channel
// (out_valid / out_stall): zero to three results per item, the final one
// flagged by out_last. Configuration port (cfg_valid / cfg_ready, always
// ready) writes page bases, erase sectors and page size by index.
// Steps: a set variable writes the live table; initialize and an erase step push
// results in the accept cycle; a readback or copy step passes through its own
// phase; a write-check step passes the first compare phase and, if equal,
// the second, as each compare of live and stored tables costs one synchronous
// table read. The next item is taken once the sequencer is back in idle.
// Results sit in a four-entry queue; the input stalls while the sequencer is
// busy or fewer than three queue slots are free, so a stalled receiver
// backs up into in_stall without loss.
// Reset clears both tables (through valid bits), the log position and the
// mode, and loads the default page layout; no clearing pass is needed.
module flash_variable_log_writer_top #(
  parameter int NUM_VARS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_var_index,
  input  logic [31:0] in_var_value,
  input  logic        in_write_ready,
  input  logic        in_read_ready,
  input  logic        in_erase_ready,
  input  logic [63:0] in_readback_record,
  input  logic        in_fresh_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [31:0] out_flash_address,
  output logic [63:0] out_record_word,
  output logic [7:0]  out_erase_sector,
  output logic        out_verify_ok,
  output logic        out_last
);
  import fvlw_pkg::*;

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  cfg_t       cfg_r;
  logic       room, in_ready, pop;
  logic [1:0] push_n;
  result_t    push_res [3];
  result_t    head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base0      <= 32'd0;
      cfg_r.base1      <= 32'd2048;
      cfg_r.base2      <= 32'd4096;
      cfg_r.sector0    <= 8'd0;
      cfg_r.sector1    <= 8'd1;
      cfg_r.sector2    <= 8'd2;
      cfg_r.page_bytes <= 21'd2048;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE0:      cfg_r.base0      <= cfg_data;
        REG_BASE1:      cfg_r.base1      <= cfg_data;
        REG_BASE2:      cfg_r.base2      <= cfg_data;
        REG_SECTOR0:    cfg_r.sector0    <= cfg_data[7:0];
        REG_SECTOR1:    cfg_r.sector1    <= cfg_data[7:0];
        REG_SECTOR2:    cfg_r.sector2    <= cfg_data[7:0];
        REG_PAGE_BYTES: cfg_r.page_bytes <= cfg_data[20:0];
        default: begin
        end
      endcase
    end
  end

  fvlw_ctrl #(.NUM_VARS(NUM_VARS), .AW(AW)) u_ctrl (
    .clk, .rst_n, .cfg(cfg_r), .room,
    .in_valid, .in_ready,
    .in_func, .in_var_index, .in_var_value, .in_write_ready, .in_read_ready,
    .in_erase_ready, .in_readback_record, .in_fresh_start,
    .push_n, .push_res
  );

  assign in_stall = !in_ready;
  assign pop      = out_valid && !out_stall;

  fvlw_outq u_outq (
    .clk, .rst_n, .push_n, .push_res, .pop,
    .head, .not_empty(out_valid), .room
  );

  assign out_command       = head.command;
  assign out_flash_address = head.flash_address;
  assign out_record_word   = head.record_word;
  assign out_erase_sector  = head.erase_sector;
  assign out_verify_ok     = head.verify_ok;
  assign out_last          = head.last;

endmodule
